// ===== hw/rtl/bship_pkg.sv =====
// Shared constants, types and operation codes of the Burning Ship escape-time block.
`default_nettype none

package bship_pkg;

	// Fixed-point format of the point c
	localparam int FRAC_BITS   = 26;
	localparam int COORD_WIDTH = 32;

	// z register width: a step from a non-escaped z stays below 2^(FRAC_BITS+4)
	localparam int ZW = FRAC_BITS + 5;
	// Magnitude width fed to the multiplier
	localparam int MW = FRAC_BITS + 4;
	// Product width and sum-of-squares width
	localparam int PW = 2 * MW;
	localparam int SW = PW + 1;
	// Width for the magnitude check of the raw input point
	localparam int XW = ((COORD_WIDTH > ZW) ? COORD_WIDTH : ZW) + 1;

	// Escape threshold: 4.0 at double fraction width
	localparam logic [SW-1:0] ESC_TH = SW'(1) << (2 * FRAC_BITS + 2);
	// Radius 2.0 at input scale
	localparam logic [XW-1:0] LIM_X  = XW'(1) << (FRAC_BITS + 1);

	// Iteration count and configuration port
	localparam int CNT_W   = 8;
	localparam int CFG_W   = 8;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FLIP     = 1'd1;
	localparam logic [CNT_W-1:0] MAX_ITER_RST = 8'd96;
	localparam logic FLIP_RST = 1'b1;

	// Palette bands in percent
	localparam int PAL_W     = 3;
	localparam int PAL_CMP_W = CNT_W + 7;
	localparam int PAL_SCALE = 100;
	localparam int PAL_BAND1 = 12;
	localparam int PAL_BAND2 = 30;
	localparam int PAL_BAND3 = 55;
	localparam int PAL_BAND4 = 80;
	localparam logic [PAL_W-1:0] PAL_INSIDE = 3'd0;
	localparam logic [PAL_W-1:0] PAL_C1     = 3'd1;
	localparam logic [PAL_W-1:0] PAL_C2     = 3'd2;
	localparam logic [PAL_W-1:0] PAL_C3     = 3'd3;
	localparam logic [PAL_W-1:0] PAL_C4     = 3'd4;
	localparam logic [PAL_W-1:0] PAL_C5     = 3'd5;

	// Shared multiplier operations
	typedef logic [1:0] mul_op_t;
	localparam mul_op_t MUL_IDLE = 2'd0;
	localparam mul_op_t MUL_RR   = 2'd1;
	localparam mul_op_t MUL_II   = 2'd2;
	localparam mul_op_t MUL_RI   = 2'd3;

	// Sequencer to datapath control
	typedef struct packed {
		logic    load;
		mul_op_t mul_op;
		logic    update;
	} dp_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/burning_ship_escape_time.sv =====
// Top level: configuration registers, iteration sequencer and result register.
//
// Usage: drive c_real/c_imag (signed, FRAC_BITS fraction bits) and raise start
// while busy is low; that edge accepts the transaction. busy stays high until
// the result is out. done rises for exactly one cycle with escape_count,
// inside_set and palette_class; the receiver cannot hold it off, so sample it.
// With max_iterations = 0 the sequencer goes straight to FINISH. Otherwise each
// step runs SQ_RE, SQ_IM and TEST, then UPDATE if it does not end there, because
// one multiplier is reused for re^2, im^2 and |re||im|, then the new z is formed.
// Stepping ends when z escapes or after max_iterations steps.
// busy falls as done rises, so the next transaction may start in the done cycle.
// Configuration: cfg_wr_en with cfg_index (0 max_iterations, 1 flip_imag) and
// cfg_wdata; write only while busy is low. Reset (arst_n low) returns to idle
// with max_iterations = 96 and flip_imag = 1, and drops done.
`default_nettype none

module burning_ship_escape_time (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     cfg_wr_en,
	input  wire logic [bship_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [bship_pkg::CFG_W-1:0]              cfg_wdata,
	input  wire logic                                     start,
	output logic                                          busy,
	input  wire logic signed [bship_pkg::COORD_WIDTH-1:0] c_real,
	input  wire logic signed [bship_pkg::COORD_WIDTH-1:0] c_imag,
	output logic                                          done,
	output logic [bship_pkg::CNT_W-1:0]                   escape_count,
	output logic                                          inside_set,
	output logic [bship_pkg::PAL_W-1:0]                   palette_class
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SQ_RE  = 3'd1;
	localparam logic [2:0] ST_SQ_IM  = 3'd2;
	localparam logic [2:0] ST_TEST   = 3'd3;
	localparam logic [2:0] ST_UPDATE = 3'd4;
	localparam logic [2:0] ST_FINISH = 3'd5;

	logic [2:0]                  state_q;
	logic [bship_pkg::CNT_W-1:0] max_iter_q;
	logic                        flip_q;
	logic [bship_pkg::CNT_W-1:0] n_q;
	logic [bship_pkg::CNT_W:0]   n_inc;
	logic                        accept;
	logic                        escaped;
	bship_pkg::dp_ctl_t          ctl;

	logic                        cls_inside;
	logic [bship_pkg::PAL_W-1:0] cls_pal;

	logic                        done_q;
	logic [bship_pkg::CNT_W-1:0] escape_count_q;
	logic                        inside_set_q;
	logic [bship_pkg::PAL_W-1:0] palette_class_q;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign n_inc  = {1'b0, n_q} + 1'b1;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q <= bship_pkg::MAX_ITER_RST;
			flip_q     <= bship_pkg::FLIP_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				bship_pkg::REG_MAX_ITER: max_iter_q <= cfg_wdata;
				bship_pkg::REG_FLIP:     flip_q     <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	// Drive the datapath from the sequencer state
	always_comb begin
		ctl.load   = accept;
		ctl.update = (state_q == ST_UPDATE);
		unique case (state_q)
			ST_SQ_RE: ctl.mul_op = bship_pkg::MUL_RR;
			ST_SQ_IM: ctl.mul_op = bship_pkg::MUL_II;
			ST_TEST:  ctl.mul_op = bship_pkg::MUL_RI;
			default:  ctl.mul_op = bship_pkg::MUL_IDLE;
		endcase
	end

	bship_datapath u_dp (
		.clk     (clk),
		.ctl     (ctl),
		.flip    (flip_q),
		.c_real  (c_real),
		.c_imag  (c_imag),
		.escaped (escaped)
	);

	// Advance the sequencer and the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						n_q     <= '0;
						state_q <= (max_iter_q == '0) ? ST_FINISH : ST_SQ_RE;
					end
				end
				ST_SQ_RE:  state_q <= ST_SQ_IM;
				ST_SQ_IM:  state_q <= ST_TEST;
				ST_TEST: begin
					if (escaped) begin
						state_q <= ST_FINISH;
					end else if (n_inc == {1'b0, max_iter_q}) begin
						n_q     <= max_iter_q;
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					n_q     <= n_inc[bship_pkg::CNT_W-1:0];
					state_q <= ST_SQ_RE;
				end
				ST_FINISH: state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	bship_class u_class (
		.count  (n_q),
		.limit  (max_iter_q),
		.in_set (cls_inside),
		.pal    (cls_pal)
	);

	// Strobe the result for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_FINISH);
		end
	end

	// Capture the result fields
	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH) begin
			escape_count_q  <= n_q;
			inside_set_q    <= cls_inside;
			palette_class_q <= cls_pal;
		end
	end

	assign done          = done_q;
	assign escape_count  = escape_count_q;
	assign inside_set    = inside_set_q;
	assign palette_class = palette_class_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted transaction did not raise busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	a_busy_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	a_inside_class: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (inside_set == (palette_class == bship_pkg::PAL_INSIDE)))
		else $error("palette class disagrees with inside flag");

	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (escape_count <= max_iter_q))
		else $error("escape count beyond iteration limit");

endmodule

`default_nettype wire

// ===== hw/rtl/bship_mul.sv =====
// Shared unsigned multiplier for squares and the cross product of z.
`default_nettype none

module bship_mul (
	input  wire logic [bship_pkg::MW-1:0] a,
	input  wire logic [bship_pkg::MW-1:0] b,
	output logic      [bship_pkg::PW-1:0] prod
);

	// Form the exact double-width product
	assign prod = bship_pkg::PW'(a) * bship_pkg::PW'(b);

endmodule

`default_nettype wire

// ===== hw/rtl/bship_class.sv =====
// Palette classifier: maps an escape count and limit to the colour band.
`default_nettype none

module bship_class (
	input  wire logic [bship_pkg::CNT_W-1:0] count,
	input  wire logic [bship_pkg::CNT_W-1:0] limit,
	output logic                             in_set,
	output logic      [bship_pkg::PAL_W-1:0] pal
);

	logic [bship_pkg::PAL_CMP_W-1:0] cnt_scaled;
	logic [bship_pkg::PAL_CMP_W-1:0] lim_b1;
	logic [bship_pkg::PAL_CMP_W-1:0] lim_b2;
	logic [bship_pkg::PAL_CMP_W-1:0] lim_b3;
	logic [bship_pkg::PAL_CMP_W-1:0] lim_b4;

	// Scale both sides so the band tests are exact integer compares
	assign cnt_scaled = bship_pkg::PAL_CMP_W'(count)
		* bship_pkg::PAL_CMP_W'(bship_pkg::PAL_SCALE);
	assign lim_b1 = bship_pkg::PAL_CMP_W'(limit) * bship_pkg::PAL_CMP_W'(bship_pkg::PAL_BAND1);
	assign lim_b2 = bship_pkg::PAL_CMP_W'(limit) * bship_pkg::PAL_CMP_W'(bship_pkg::PAL_BAND2);
	assign lim_b3 = bship_pkg::PAL_CMP_W'(limit) * bship_pkg::PAL_CMP_W'(bship_pkg::PAL_BAND3);
	assign lim_b4 = bship_pkg::PAL_CMP_W'(limit) * bship_pkg::PAL_CMP_W'(bship_pkg::PAL_BAND4);

	assign in_set = (count == limit);

	// Inside points get PAL_INSIDE; else pick the lowest band that the count fraction falls under
	always_comb begin
		priority if (in_set) begin
			pal = bship_pkg::PAL_INSIDE;
		end else if (cnt_scaled < lim_b1) begin
			pal = bship_pkg::PAL_C1;
		end else if (cnt_scaled < lim_b2) begin
			pal = bship_pkg::PAL_C2;
		end else if (cnt_scaled < lim_b3) begin
			pal = bship_pkg::PAL_C3;
		end else if (cnt_scaled < lim_b4) begin
			pal = bship_pkg::PAL_C4;
		end else begin
			pal = bship_pkg::PAL_C5;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/bship_datapath.sv =====
// Datapath: z and c registers, product registers, escape test and z update.
`default_nettype none

module bship_datapath (
	input  wire logic                                 clk,
	input  wire bship_pkg::dp_ctl_t                   ctl,
	input  wire logic                                 flip,
	input  wire logic signed [bship_pkg::COORD_WIDTH-1:0] c_real,
	input  wire logic signed [bship_pkg::COORD_WIDTH-1:0] c_imag,
	output logic                                      escaped
);

	logic signed [bship_pkg::XW-1:0] cr_x;
	logic signed [bship_pkg::XW-1:0] ci_x;
	logic        [bship_pkg::XW-1:0] cr_abs;
	logic        [bship_pkg::XW-1:0] ci_abs;
	logic signed [bship_pkg::ZW-1:0] ci_z;
	logic signed [bship_pkg::ZW-1:0] ce_load;
	logic                            big_load;

	logic signed [bship_pkg::ZW-1:0] cr_q;
	logic signed [bship_pkg::ZW-1:0] ce_q;
	logic signed [bship_pkg::ZW-1:0] re_q;
	logic signed [bship_pkg::ZW-1:0] im_q;
	logic                            big_q;
	logic        [bship_pkg::PW-1:0] sr_q;
	logic        [bship_pkg::PW-1:0] si_q;
	logic        [bship_pkg::PW-1:0] p_q;

	logic        [bship_pkg::ZW-1:0] re_abs;
	logic        [bship_pkg::ZW-1:0] im_abs;
	logic        [bship_pkg::MW-1:0] mul_a;
	logic        [bship_pkg::MW-1:0] mul_b;
	logic        [bship_pkg::PW-1:0] prod;

	logic        [bship_pkg::SW-1:0] sq_sum;
	logic signed [bship_pkg::SW-1:0] sq_diff;
	logic signed [bship_pkg::SW-1:0] diff_sh;
	logic        [bship_pkg::PW-1:0] p_sh;
	logic signed [bship_pkg::ZW-1:0] re_next;
	logic signed [bship_pkg::ZW-1:0] im_next;

	// Check each raw coordinate magnitude against 2.0 before it is narrowed
	assign cr_x     = bship_pkg::XW'(c_real);
	assign ci_x     = bship_pkg::XW'(c_imag);
	assign cr_abs   = cr_x[bship_pkg::XW-1] ? -cr_x : cr_x;
	assign ci_abs   = ci_x[bship_pkg::XW-1] ? -ci_x : ci_x;
	assign big_load = (cr_abs > bship_pkg::LIM_X) || (ci_abs > bship_pkg::LIM_X);
	assign ci_z     = ci_x[bship_pkg::ZW-1:0];
	assign ce_load  = flip ? -ci_z : ci_z;

	// Magnitudes of the current z
	assign re_abs = re_q[bship_pkg::ZW-1] ? -re_q : re_q;
	assign im_abs = im_q[bship_pkg::ZW-1] ? -im_q : im_q;

	// Route operands to the shared multiplier
	always_comb begin
		unique case (ctl.mul_op)
			bship_pkg::MUL_RR: begin
				mul_a = re_abs[bship_pkg::MW-1:0];
				mul_b = re_abs[bship_pkg::MW-1:0];
			end
			bship_pkg::MUL_II: begin
				mul_a = im_abs[bship_pkg::MW-1:0];
				mul_b = im_abs[bship_pkg::MW-1:0];
			end
			bship_pkg::MUL_RI: begin
				mul_a = re_abs[bship_pkg::MW-1:0];
				mul_b = im_abs[bship_pkg::MW-1:0];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	bship_mul u_mul (
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	// Escape test on the exact sum of squares, or on the flag for a too-large raw point
	assign sq_sum  = {1'b0, sr_q} + {1'b0, si_q};
	assign escaped = big_q || (sq_sum > bship_pkg::ESC_TH);

	// Next z: floor-shifted square difference and doubled cross product, plus c
	assign sq_diff = $signed({1'b0, sr_q}) - $signed({1'b0, si_q});
	assign diff_sh = sq_diff >>> bship_pkg::FRAC_BITS;
	assign p_sh    = p_q >> (bship_pkg::FRAC_BITS - 1);
	assign re_next = $signed(diff_sh[bship_pkg::ZW-1:0]) + cr_q;
	assign im_next = $signed(p_sh[bship_pkg::ZW-1:0]) + ce_q;

	// Load c, capture products, advance z
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cr_q  <= cr_x[bship_pkg::ZW-1:0];
			ce_q  <= ce_load;
			re_q  <= cr_x[bship_pkg::ZW-1:0];
			im_q  <= ce_load;
			big_q <= big_load;
		end else if (ctl.update) begin
			re_q <= re_next;
			im_q <= im_next;
		end
		unique case (ctl.mul_op)
			bship_pkg::MUL_RR: sr_q <= prod;
			bship_pkg::MUL_II: si_q <= prod;
			bship_pkg::MUL_RI: p_q  <= prod;
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire
